FILE: rtl/core/chte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chte_pkg
// Shared constants for the chained hash table engine.
// ----------------------------------------------------------------------------
package chte_pkg;
	localparam int MaxRecords = 256;
	localparam int AddrW = $clog2(MaxRecords);
	localparam int CountW = $clog2(MaxRecords + 1);
	localparam int KeyW = 44;
	localparam int PayW = 32;
	localparam int CfgW = 9;
	localparam int BktW = 12;
	localparam int IdxW = 11;
	localparam int StatW = 3;
	localparam int EntW = 9;
	localparam int RemW = BktW + 1;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_FIND   = 2'd1;
	localparam logic [1:0] CMD_DELETE = 2'd2;

	localparam logic [StatW-1:0] ST_INSERTED = 3'd0;
	localparam logic [StatW-1:0] ST_FOUND    = 3'd1;
	localparam logic [StatW-1:0] ST_NOTFOUND = 3'd2;
	localparam logic [StatW-1:0] ST_DELETED  = 3'd3;
	localparam logic [StatW-1:0] ST_DELFAIL  = 3'd4;
	localparam logic [StatW-1:0] ST_FULL     = 3'd5;

	localparam logic [BktW-1:0] BucketLimit = 12'd2048;
	localparam logic [CfgW-1:0] InitBucketsRst = 9'd10;
endpackage

FILE: rtl/core/chte_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chte_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
module chte_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

FILE: rtl/core/chte_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chte_mod
// Restoring bit-serial remainder: key modulo bucket count, one bit a cycle.
// ----------------------------------------------------------------------------
module chte_mod (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         go,
	input  logic [chte_pkg::KeyW-1:0]    key,
	input  logic [chte_pkg::BktW-1:0]    divisor,
	output logic                         done,
	output logic [chte_pkg::IdxW-1:0]    rem
);
	localparam int CntW = $clog2(chte_pkg::KeyW + 1);

	logic [chte_pkg::KeyW-1:0] shf_q;
	logic [chte_pkg::RemW-1:0] rem_q;
	logic [chte_pkg::BktW-1:0] div_q;
	logic [CntW-1:0]           cnt_q;
	logic                      run_q;
	logic [chte_pkg::RemW-1:0] trial;
	logic [chte_pkg::RemW-1:0] dext;

	assign trial = {rem_q[chte_pkg::RemW-2:0], shf_q[chte_pkg::KeyW-1]};
	assign dext = {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CntW'(chte_pkg::KeyW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			shf_q <= key;
			rem_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			shf_q <= {shf_q[chte_pkg::KeyW-2:0], 1'b0};
			rem_q <= (trial >= dext) ? trial - dext : trial;
		end
	end

	assign rem = rem_q[chte_pkg::IdxW-1:0];
endmodule

FILE: rtl/core/chained_hash_table_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_table_engine
// Insertion-ordered record store with modulo bucket hashing and growth.
// ----------------------------------------------------------------------------
// channel  | ports                                   | handshake
// command  | start, command, key, payload            | start & !busy
// result   | status, found_payload, bucket_index,    | done strobe, 1 cycle
//          | buckets_now, entries_now                |
// config   | cfg_we, cfg_wdata                       | cfg_we
// The remainder unit takes one key bit a cycle, then raises done to hand
// off. Find and delete then scan the records, each through S_SCAN and S_CHK
// (RAM read is registered); delete closes up the tail, each record through
// S_SHR and S_SHW. Busy covers the remainder pass, and for find and delete
// also the record scan and tail shift; done follows in the next cycle, when
// busy is already low. No clearing pass after reset; result cannot stall.
// ----------------------------------------------------------------------------
module chained_hash_table_engine (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        command,
	input  logic [chte_pkg::KeyW-1:0]         key,
	input  logic [chte_pkg::PayW-1:0]         payload,
	input  logic                              cfg_we,
	input  logic [chte_pkg::CfgW-1:0]         cfg_wdata,
	output logic                              done,
	output logic [chte_pkg::StatW-1:0]        status,
	output logic [chte_pkg::PayW-1:0]         found_payload,
	output logic [chte_pkg::IdxW-1:0]         bucket_index,
	output logic [chte_pkg::BktW-1:0]         buckets_now,
	output logic [chte_pkg::EntW-1:0]         entries_now
);
	localparam int AW = chte_pkg::AddrW;
	localparam int CW = chte_pkg::CountW;
	localparam int RW = chte_pkg::KeyW + chte_pkg::PayW;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MOD  = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_CHK  = 3'd3;
	localparam logic [2:0] S_SHR  = 3'd4;
	localparam logic [2:0] S_SHW  = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0]                 state_q;
	logic [1:0]                 cmd_q;
	logic [chte_pkg::KeyW-1:0]  key_q;
	logic [chte_pkg::PayW-1:0]  pay_q;
	logic [CW-1:0]              live_q;
	logic [chte_pkg::BktW-1:0]  bkt_q;
	logic [CW-1:0]              pos_q;
	logic [chte_pkg::StatW-1:0] stat_q;
	logic [chte_pkg::PayW-1:0]  fpay_q;
	logic [chte_pkg::IdxW-1:0]  bidx_q;

	logic                       mod_go;
	logic                       mod_done;
	logic [chte_pkg::IdxW-1:0]  mod_rem;

	logic                       we;
	logic [AW-1:0]              waddr;
	logic [RW-1:0]              wdata;
	logic [AW-1:0]              raddr;
	logic [RW-1:0]              rdata;
	logic [CW-1:0]              live_inc;
	logic [chte_pkg::BktW+2:0]  lhs;
	logic [chte_pkg::BktW+2:0]  rhs;
	logic [chte_pkg::BktW-1:0]  cfg_bkt;

	assign busy = (state_q != S_IDLE);
	assign mod_go = start && !busy;
	assign cfg_bkt = (cfg_wdata == '0) ? chte_pkg::BktW'(1)
		: chte_pkg::BktW'(cfg_wdata);

	assign live_inc = live_q + 1'b1;
	assign lhs = (chte_pkg::BktW+3)'(live_inc) << 2;
	assign rhs = (chte_pkg::BktW+3)'(bkt_q) * (chte_pkg::BktW+3)'(3);

	chte_mod u_mod (
		.clk(clk), .arst_n(arst_n), .go(mod_go), .key(key),
		.divisor(bkt_q), .done(mod_done), .rem(mod_rem)
	);

	chte_ram #(.Width(RW), .Depth(chte_pkg::MaxRecords)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	always_comb begin
		we = 1'b0;
		waddr = live_q[AW-1:0];
		wdata = {key_q, pay_q};
		raddr = pos_q[AW-1:0];
		if (state_q == S_MOD && mod_done && cmd_q == chte_pkg::CMD_INSERT
				&& live_q < CW'(chte_pkg::MaxRecords)) begin
			we = 1'b1;
		end else if (state_q == S_SHW) begin
			// rdata holds record pos+1; move it down one slot
			we = 1'b1;
			waddr = pos_q[AW-1:0];
			wdata = rdata;
		end
		if (state_q == S_SHR) raddr = AW'(pos_q + 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			live_q <= '0;
			bkt_q <= chte_pkg::BktW'(chte_pkg::InitBucketsRst);
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cfg_we) bkt_q <= cfg_bkt;
					if (mod_go) state_q <= S_MOD;
				end
				S_MOD: begin
					if (mod_done) begin
						if (cmd_q == chte_pkg::CMD_INSERT) begin
							if (live_q < CW'(chte_pkg::MaxRecords)) begin
								live_q <= live_inc;
								if (lhs >= rhs && ({1'b0, bkt_q} << 1)
										<= {1'b0, chte_pkg::BucketLimit})
									bkt_q <= bkt_q << 1;
							end
							state_q <= S_DONE;
						end else if (cmd_q == chte_pkg::CMD_FIND
								|| cmd_q == chte_pkg::CMD_DELETE) begin
							state_q <= (live_q == '0) ? S_DONE : S_SCAN;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN: state_q <= S_CHK;
				S_CHK: begin
					if (rdata[RW-1 -: chte_pkg::KeyW] == key_q) begin
						if (cmd_q == chte_pkg::CMD_DELETE) begin
							if (pos_q + 1'b1 >= live_q) begin
								live_q <= live_q - 1'b1;
								state_q <= S_DONE;
							end else begin
								state_q <= S_SHR;
							end
						end else begin
							state_q <= S_DONE;
						end
					end else if (pos_q + 1'b1 >= live_q) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SHR: state_q <= S_SHW;
				S_SHW: begin
					if (pos_q + CW'(2) >= live_q) begin
						live_q <= live_q - 1'b1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_SHR;
					end
				end
				S_DONE: begin
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q <= command;
				key_q <= key;
				pay_q <= payload;
				pos_q <= '0;
				fpay_q <= '0;
				stat_q <= chte_pkg::ST_NOTFOUND;
			end
			S_MOD: begin
				if (mod_done) begin
					bidx_q <= mod_rem;
					if (cmd_q == chte_pkg::CMD_INSERT)
						stat_q <= (live_q < CW'(chte_pkg::MaxRecords))
							? chte_pkg::ST_INSERTED : chte_pkg::ST_FULL;
					else if (cmd_q == chte_pkg::CMD_DELETE)
						stat_q <= chte_pkg::ST_DELFAIL;
				end
			end
			S_CHK: begin
				if (rdata[RW-1 -: chte_pkg::KeyW] == key_q) begin
					if (cmd_q == chte_pkg::CMD_DELETE) begin
						stat_q <= chte_pkg::ST_DELETED;
					end else begin
						stat_q <= chte_pkg::ST_FOUND;
						fpay_q <= rdata[chte_pkg::PayW-1:0];
					end
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
			S_SHW: pos_q <= pos_q + 1'b1;
			default: ;
		endcase
	end

	assign status = stat_q;
	assign found_payload = fpay_q;
	assign bucket_index = bidx_q;
	assign buckets_now = bkt_q;
	assign entries_now = chte_pkg::EntW'(live_q);
endmodule
